@@ design/lfc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfc_pkg: shared types and constants of the straight line fit
// Widths, state codes and the controller to datapath command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package lfc_pkg;
   localparam int MAX_POINTS = 8;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 24;
   localparam int SUM_W      = COORD_W + CNT_W + 1;
   localparam int PSUM_W     = 2 * COORD_W + CNT_W + 1;
   localparam int NUM_W      = PSUM_W + CNT_W + 2;
   localparam int DIV_STEPS  = 128;
   localparam int STEP_W     = 8;
   localparam int MUL_CYCLES = 2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DEGEN    = 2'd1,
      STATUS_DROPPED  = 2'd2,
      STATUS_RSVD     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_PREP1,
      ST_PREP2,
      ST_CHECK,
      ST_KDIV,
      ST_KFIN,
      ST_BPREP,
      ST_BDIV,
      ST_BFIN,
      ST_RES1,
      ST_RES2,
      ST_RES3,
      ST_RES4,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accumulate;
      logic prep1;
      logic prep2;
      logic kdiv_start;
      logic kdiv_step;
      logic kfin;
      logic bprep;
      logic bdiv_step;
      logic bfin;
      logic res1;
      logic res2;
      logic res3;
      logic degenerate;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic             den_bad;
      logic             div_done;
      logic             res_last;
      logic [CNT_W-1:0] count;
   } sts_type;
endpackage
`default_nettype wire

@@ design/lfc_if.sv @@
// ----------------------------------------------------------------------------
// lfc_req_if / lfc_rsp_if: valid/ready channels of the line fit
// Points in, fit results out.
// ----------------------------------------------------------------------------
`default_nettype none
interface lfc_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;
   logic               last_point;
   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface lfc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] slope;
   logic signed [31:0] intercept;
   logic        [39:0] chi_square;
   logic        [1:0]  fit_status;
   modport source (output valid, slope, intercept, chi_square, fit_status, input ready);
   modport sink   (input valid, slope, intercept, chi_square, fit_status, output ready);
endinterface
`default_nettype wire

@@ design/line_fit_with_chi_square.sv @@
// ----------------------------------------------------------------------------
// line_fit_with_chi_square: least squares straight line fit of one track
// Points are taken one per cycle while the block collects. After the
// marked last point the block runs a 128-step restoring division for the
// slope and a 64-step one for the intercept through one shared divider,
// then a residual pass (read, multiply, square) per stored point, or skips
// both for a degenerate fit, before the result is loaded into the output
// register; the next track is taken in the cycle after the load.
// ----------------------------------------------------------------------------
`default_nettype none
module line_fit_with_chi_square (
   input wire logic clock,
   input wire logic reset,
   lfc_req_if.sink  req,
   lfc_rsp_if.source rsp
);
   import lfc_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_fire, req_rdy, result_load, degen, dropped;
   logic    rsp_valid_ff;
   logic signed [31:0] slope, intercept;
   logic        [39:0] chi;
   logic signed [31:0] slope_ff, intercept_ff;
   logic        [39:0] chi_ff;
   status_type         status_ff;

   assign req_fire  = req.valid && req_rdy;
   assign req.ready = req_rdy;

   lfc_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_last(req.last_point),
      .rsp_free(!rsp_valid_ff || rsp.ready), .sts, .cmd,
      .req_ready(req_rdy), .result_load, .degen_ff(degen)
   );

   lfc_datapath u_dp (
      .clock, .reset, .cmd, .sts, .in_x(req.point_x), .in_y(req.point_y),
      .slope, .intercept, .chi_square(chi), .dropped
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (result_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         slope_ff     <= slope;
         intercept_ff <= intercept;
         chi_ff       <= chi;
         status_ff    <= degen ? STATUS_DEGEN : (dropped ? STATUS_DROPPED : STATUS_OK);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.slope      = slope_ff;
   assign rsp.intercept  = intercept_ff;
   assign rsp.chi_square = chi_ff;
   assign rsp.fit_status = status_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.slope))
      else $error("transaction dropped");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.fit_status != STATUS_RSVD) else $error("bad status");
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.fit_status == STATUS_DEGEN |-> rsp.slope == 0)
      else $error("degenerate slope");
`endif
endmodule
`default_nettype wire

@@ design/lfc_datapath.sv @@
// ----------------------------------------------------------------------------
// lfc_datapath: sums, point store, shared divider and residual pass
// Executes the controller's commands one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lfc_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lfc_pkg::cmd_type          cmd,
   output      lfc_pkg::sts_type          sts,
   input  wire logic signed [23:0]        in_x,
   input  wire logic signed [23:0]        in_y,
   output      logic signed [31:0]        slope,
   output      logic signed [31:0]        intercept,
   output      logic        [39:0]        chi_square,
   output      logic                      dropped
);
   import lfc_pkg::*;

   localparam logic [39:0] CHI_MAX = '1;

   logic signed [23:0] x_mem [MAX_POINTS];
   logic signed [23:0] y_mem [MAX_POINTS];

   logic signed [SUM_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic signed [PSUM_W-1:0] sxy_ff, sxy_in, sxx_ff, sxx_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     ovf_ff, ovf_in;

   logic signed [NUM_W-1:0]  pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [NUM_W-1:0]  num_ff, den_ff;

   logic [127:0]  dvd_ff;
   logic [63:0]   rem_ff, q_ff, dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic          big_ff, neg_ff;

   logic signed [31:0] k_ff, b_ff;
   logic signed [63:0] t_ff;
   logic [39:0]   chi_ff;
   logic [IDX_W-1:0] ri_ff;
   logic signed [23:0] rx_ff, ry_ff;
   logic signed [63:0] kx_ff;
   logic [25:0]   rm_ff;
   logic          rbig_ff, rvalid_ff, rlast_ff;
   logic [CNT_W-1:0] rcnt_ff;

   logic [64:0]   rem_sh;
   logic [63:0]   q_sh;
   logic          can_store;
   logic signed [63:0] r_full;
   logic [63:0]   r_mag, r_rnd;
   logic [51:0]   sq;
   logic [42:0]   chi_sum;
   logic [63:0]   qmag;
   logic [31:0]   sat_v;

   assign can_store = cnt_ff < CNT_W'(MAX_POINTS);

   always_comb begin
      sx_in  = sx_ff;  sy_in = sy_ff; sxy_in = sxy_ff; sxx_in = sxx_ff;
      cnt_in = cnt_ff; ovf_in = ovf_ff;
      if (cmd.clear) begin
         sx_in = '0; sy_in = '0; sxy_in = '0; sxx_in = '0;
         cnt_in = '0; ovf_in = 1'b0;
      end else if (cmd.accumulate) begin
         if (can_store) begin
            sx_in  = sx_ff + SUM_W'(in_x);
            sy_in  = sy_ff + SUM_W'(in_y);
            sxy_in = sxy_ff + PSUM_W'(in_x * in_y);
            sxx_in = sxx_ff + PSUM_W'(in_x * in_x);
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= '0; sy_ff <= '0; sxy_ff <= '0; sxx_ff <= '0;
         cnt_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         sx_ff <= sx_in; sy_ff <= sy_in; sxy_ff <= sxy_in; sxx_ff <= sxx_in;
         cnt_ff <= cnt_in; ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accumulate && can_store) begin
         x_mem[cnt_ff[IDX_W-1:0]] <= in_x;
         y_mem[cnt_ff[IDX_W-1:0]] <= in_y;
      end
   end

   // normal equations: products, then differences
   always_ff @(posedge clock) begin
      if (cmd.prep1) begin
         pa_ff <= NUM_W'($signed({1'b0, cnt_ff})) * NUM_W'(sxy_ff);
         pb_ff <= NUM_W'(sx_ff) * NUM_W'(sy_ff);
         pc_ff <= NUM_W'($signed({1'b0, cnt_ff})) * NUM_W'(sxx_ff);
         pd_ff <= NUM_W'(sx_ff) * NUM_W'(sx_ff);
      end
      if (cmd.prep2) begin
         num_ff <= pa_ff - pb_ff;
         den_ff <= pc_ff - pd_ff;
      end
   end

   // restoring divider, one quotient bit per cycle, shared by k and b
   assign rem_sh = {rem_ff, dvd_ff[127]};
   assign q_sh   = q_ff << 1;

   always_ff @(posedge clock) begin
      if (cmd.kdiv_start) begin
         dvd_ff  <= {40'd0, (num_ff < 0) ? 64'(-num_ff) : 64'(num_ff), 24'd0};
         dvs_ff  <= 64'(den_ff);
         neg_ff  <= num_ff < 0;
         rem_ff  <= '0;
         q_ff    <= '0;
         big_ff  <= 1'b0;
         step_ff <= '0;
      end else if (cmd.bprep) begin
         dvd_ff  <= {(t_ff < 0) ? 64'(-t_ff) : 64'(t_ff), 64'd0};
         dvs_ff  <= 64'({cnt_ff, 24'd0});
         neg_ff  <= t_ff < 0;
         rem_ff  <= '0;
         q_ff    <= '0;
         big_ff  <= 1'b0;
         step_ff <= STEP_W'(DIV_STEPS - 64);
      end else if (cmd.kdiv_step || cmd.bdiv_step) begin
         dvd_ff  <= dvd_ff << 1;
         step_ff <= step_ff + STEP_W'(1);
         if (q_ff[63:62] != 2'b00) big_ff <= 1'b1;
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_ff <= 64'(rem_sh - {1'b0, dvs_ff});
            q_ff   <= q_sh | 64'd1;
         end else begin
            rem_ff <= rem_sh[63:0];
            q_ff   <= q_sh;
         end
      end
   end

   always_comb begin
      qmag = q_ff;
      if (cmd.kfin) begin
         if ({rem_ff, 1'b0} >= {1'b0, dvs_ff}) qmag = q_ff + 64'd1;
         if (big_ff) qmag = '1;
      end else begin
         if ({rem_ff, 1'b0} >= {1'b0, dvs_ff}) qmag = q_ff + 64'd1;
      end
      if (neg_ff) sat_v = (qmag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-qmag);
      else        sat_v = (qmag >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qmag[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.degenerate) begin
         k_ff <= '0; b_ff <= '0;
      end else begin
         if (cmd.kfin) k_ff <= $signed(sat_v);
         if (cmd.bfin) b_ff <= $signed(sat_v);
      end
      if (cmd.kfin) t_ff <= (64'(sy_ff) <<< 24) - 64'($signed(sat_v)) * 64'(sx_ff);
   end

   // residual pass: read, multiply, square and accumulate
   assign r_full = (64'(ry_ff) <<< 24) - kx_ff - (64'(b_ff) <<< 24);
   assign r_mag  = r_full[63] ? 64'(-r_full) : 64'(r_full);
   assign r_rnd  = (r_mag + 64'd524288) >> 20;
   assign sq     = (52'(rm_ff) * 52'(rm_ff) + 52'd128) >> 8;
   assign chi_sum = {3'b000, chi_ff} + 43'(sq);

   always_ff @(posedge clock) begin
      if (cmd.res1) begin
         rx_ff <= x_mem[ri_ff];
         ry_ff <= y_mem[ri_ff];
      end
      if (cmd.res2) kx_ff <= 64'(k_ff) * 64'(rx_ff);
      if (cmd.res3) begin
         rm_ff   <= r_rnd[25:0];
         rbig_ff <= r_rnd >= 64'd33554432;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear || cmd.bfin || cmd.degenerate) begin
         ri_ff     <= '0;
         rcnt_ff   <= '0;
         rvalid_ff <= 1'b0;
         if (reset || cmd.clear || cmd.bfin || cmd.degenerate) chi_ff <= '0;
      end else begin
         if (cmd.res3) begin
            ri_ff   <= ri_ff + IDX_W'(1);
            rcnt_ff <= rcnt_ff + CNT_W'(1);
         end
         rvalid_ff <= cmd.res3;
         if (rvalid_ff) begin
            if (rbig_ff || chi_sum[42:40] != 3'b000) chi_ff <= CHI_MAX;
            else                                     chi_ff <= chi_sum[39:0];
         end
      end
   end

   assign rlast_ff = 1'b0;
   assign sts.den_bad  = (cnt_ff < CNT_W'(2)) || (den_ff <= 0);
   assign sts.div_done = step_ff == STEP_W'(DIV_STEPS - 1);
   assign sts.res_last = (rcnt_ff + CNT_W'(1)) >= cnt_ff || rlast_ff;
   assign sts.count    = cnt_ff;

   assign slope      = k_ff;
   assign intercept  = b_ff;
   assign chi_square = chi_ff;
   assign dropped    = ovf_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS)) else $error("hit count beyond capacity");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> cnt_ff == '0 && !ovf_ff) else $error("track not cleared");
   a_chi_sat: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && rbig_ff |=> chi_ff == CHI_MAX) else $error("chi not saturated");
`endif
endmodule
`default_nettype wire

@@ design/lfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfc_ctrl: sequencer of the line fit
// Collects points, then steps the datapath through divide and residuals.
// ----------------------------------------------------------------------------
`default_nettype none
module lfc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_fire,
   input  wire logic             req_last,
   input  wire logic             rsp_free,
   input  wire lfc_pkg::sts_type sts,
   output      lfc_pkg::cmd_type cmd,
   output      logic             req_ready,
   output      logic             result_load,
   output      logic             degen_ff
);
   import lfc_pkg::*;

   state_type state_ff, state_in;
   logic      degen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         degen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         degen_ff <= degen_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      degen_in    = degen_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      result_load = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_ready      = 1'b1;
            cmd.accumulate = req_fire;
            if (req_fire && req_last) state_in = ST_PREP1;
         end
         ST_PREP1: begin cmd.prep1 = 1'b1; state_in = ST_PREP2; end
         ST_PREP2: begin cmd.prep2 = 1'b1; state_in = ST_CHECK; end
         ST_CHECK: begin
            if (sts.den_bad) begin
               cmd.degenerate = 1'b1;
               degen_in       = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               cmd.kdiv_start = 1'b1;
               degen_in       = 1'b0;
               state_in       = ST_KDIV;
            end
         end
         ST_KDIV: begin
            cmd.kdiv_step = 1'b1;
            if (sts.div_done) state_in = ST_KFIN;
         end
         ST_KFIN: begin cmd.kfin = 1'b1; state_in = ST_BPREP; end
         ST_BPREP: begin cmd.bprep = 1'b1; state_in = ST_BDIV; end
         ST_BDIV: begin
            cmd.bdiv_step = 1'b1;
            if (sts.div_done) state_in = ST_BFIN;
         end
         ST_BFIN: begin cmd.bfin = 1'b1; state_in = ST_RES1; end
         ST_RES1: begin cmd.res1 = 1'b1; state_in = ST_RES2; end
         ST_RES2: begin cmd.res2 = 1'b1; state_in = ST_RES3; end
         ST_RES3: begin
            cmd.res3 = 1'b1;
            state_in = sts.res_last ? ST_RES4 : ST_RES1;
         end
         // let the last square reach the sum
         ST_RES4: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               result_load = 1'b1;
               cmd.clear   = 1'b1;
               state_in    = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

`ifndef SYNTHESIS
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_COLLECT) else $error("ready outside collect");
   a_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last |=> state_ff == ST_PREP1) else $error("fit not started");
   a_load: assert property (@(posedge clock) disable iff (reset)
      result_load |-> rsp_free) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

@@ tb/lfc_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// lfc_tb_pkg: transaction types of the line fit testbench
// Point and fit result records shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package lfc_tb_pkg;
   import lfc_pkg::*;

   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic               last;
   } hit_type;

   typedef struct {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic        [39:0] chi;
      status_type         status;
   } fit_type;
endpackage

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: line_fit_with_chi_square testbench
// Tracks of points are fed through a randomly idling driver. A predictor of
// the least squares fit with chi-square builds the expected fit of each
// track, and a monitor with random back-pressure compares every result field
// by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lfc_pkg::*;
   import lfc_tb_pkg::*;

   localparam longint CHI_TOP = (64'd1 << 40) - 1;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfc_req_if req ();
   lfc_rsp_if rsp ();

   line_fit_with_chi_square dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hit_type pending_hits[$];
   fit_type expected_fits[$];
   longint  track_x[MAX_POINTS];
   longint  track_y[MAX_POINTS];
   longint  sx, sy, sxy, sxx;
   int      stored;
   bit      dropped;
   int      mismatches = 0;
   int      fits_seen = 0;
   int      hits_sent = 0;
   int      degen_seen = 0;
   int      drop_seen = 0;
   longint  cycles = 0;
   bit      hold_sender = 1'b0;
   int      send_gap = 0;
   int      take_gap = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint clamp32(longint m, bit neg);
      if (neg) return (m >= 64'h8000_0000) ? -64'sh8000_0000 : -m;
      return (m >= 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : m;
   endfunction

   function automatic longint round_shift(longint v, int s);
      longint m;
      m = (magnitude(v) + (64'sd1 <<< (s - 1))) >>> s;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint slope_quotient(longint num, longint den);
      logic [127:0] dividend;
      logic [127:0] q;
      logic [127:0] rem;
      longint m;
      m = magnitude(num);
      dividend = {64'd0, m} << 24;
      q = dividend / den;
      rem = dividend % den;
      if (2 * rem >= den) q = q + 1;
      if (q > 128'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
      else m = q[63:0];
      return clamp32(m, num < 0);
   endfunction

   function automatic void clear_track_sums();
      sx = 0; sy = 0; sxy = 0; sxx = 0;
      stored = 0;
      dropped = 1'b0;
   endfunction

   function automatic void predict_hit(hit_type h);
      longint x, y, n, num, den, k, b, t, d, chi, r, rm;
      fit_type f;
      x = h.x;
      y = h.y;
      if (stored < MAX_POINTS) begin
         track_x[stored] = x;
         track_y[stored] = y;
         stored++;
         sx += x; sy += y; sxy += x * y; sxx += x * x;
      end else begin
         dropped = 1'b1;
      end
      if (!h.last) return;
      n = stored;
      num = n * sxy - sx * sy;
      den = n * sxx - sx * sx;
      k = 0; b = 0; chi = 0;
      if (n < 2 || den <= 0) begin
         f.status = STATUS_DEGEN;
      end else begin
         f.status = dropped ? STATUS_DROPPED : STATUS_OK;
         k = slope_quotient(num, den);
         t = sy * (64'sd1 <<< 24) - k * sx;
         d = n <<< 24;
         b = clamp32((magnitude(t) + d / 2) / d, t < 0);
         for (int i = 0; i < stored; i++) begin
            r = track_y[i] * (64'sd1 <<< 24) - k * track_x[i] - b * (64'sd1 <<< 24);
            rm = magnitude(round_shift(r, 20));
            if (rm >= (64'sd1 <<< 25)) begin
               chi = CHI_TOP;
            end else begin
               chi += (rm * rm + 128) >>> 8;
               if (chi > CHI_TOP) chi = CHI_TOP;
            end
         end
      end
      f.slope = k[31:0];
      f.intercept = b[31:0];
      f.chi = chi[39:0];
      expected_fits.push_back(f);
      clear_track_sums();
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("line_fit_with_chi_square verification failed");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.point_x <= '0;
         req.point_y <= '0;
         req.last_point <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            predict_hit(pending_hits.pop_front());
            hits_sent++;
         end
         if (req.valid && !req.ready) begin
            // hold
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_hits.size() > 0 && !hold_sender) begin
            req.point_x <= pending_hits[0].x;
            req.point_y <= pending_hits[0].y;
            req.last_point <= pending_hits[0].last;
            req.valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fit_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            fits_seen++;
            if (expected_fits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected fit: slope %h intercept %h chi %h status %0d",
                           rsp.slope, rsp.intercept, rsp.chi_square, rsp.fit_status);
            end else begin
               e = expected_fits.pop_front();
               if (e.status == STATUS_DEGEN) degen_seen++;
               if (e.status == STATUS_DROPPED) drop_seen++;
               if (rsp.slope !== e.slope || rsp.intercept !== e.intercept ||
                   rsp.chi_square !== e.chi || rsp.fit_status !== e.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("fit %0d mismatch: slope %h/%h intercept %h/%h chi %h/%h status %0d/%0d",
                              fits_seen, e.slope, rsp.slope, e.intercept, rsp.intercept,
                              e.chi, rsp.chi_square, e.status, rsp.fit_status);
               end
            end
         end
         if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) take_gap <= pick_gap();
         end
      end
   end

   function automatic logic signed [23:0] pick_coord(int style);
      case (style)
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 4000)) - 2000);
         default: return 24'($signed($urandom_range(0, 80000)) - 40000);
      endcase
   endfunction

   task automatic add_hit(logic signed [23:0] x, logic signed [23:0] y, logic last);
      hit_type h;
      h.x = x; h.y = y; h.last = last;
      pending_hits.push_back(h);
   endtask

   task automatic add_random_track();
      int n, style, kq, bq;
      logic signed [23:0] x;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      style = $urandom_range(0, 3);
      kq = $signed($urandom_range(0, 2000)) - 1000;
      bq = $signed($urandom_range(0, 20000)) - 10000;
      for (int i = 0; i < n; i++) begin
         if (style == 3) begin
            x = 24'($signed($urandom_range(0, 6000)) - 3000);
            add_hit(x, 24'((x * kq) / 256 + bq + $signed($urandom_range(0, 60)) - 30),
                    i == n - 1);
         end else begin
            x = ($urandom_range(0, 15) == 0 && i > 0) ? pending_hits[$].x
                                                      : pick_coord(style);
            add_hit(x, pick_coord(style), i == n - 1);
         end
      end
   endtask

   task automatic drain();
      while (pending_hits.size() > 0 || expected_fits.size() > 0 || req.valid)
         @(posedge clock);
   endtask

   initial begin
      clear_track_sums();
      req.valid = 1'b0;
      req.point_x = '0;
      req.point_y = '0;
      req.last_point = 1'b0;
      rsp.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single point, two equal x, extremes, two-point exact line
      add_hit(24'sd100, 24'sd5, 1'b1);
      add_hit(24'sd300, 24'sd1, 1'b0);
      add_hit(24'sd300, -24'sd7, 1'b1);
      add_hit(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
      add_hit(24'sh800000, 24'sh800000, 1'b0);
      add_hit(24'sd0, 24'sh7FFFFF, 1'b1);
      add_hit(-24'sd512, -24'sd256, 1'b0);
      add_hit(24'sd512, 24'sd768, 1'b1);
      add_hit(24'sh800000, 24'sh7FFFFF, 1'b0);
      add_hit(24'sh7FFFFF, 24'sh800000, 1'b1);
      // over capacity, with the marked point dropped
      for (int i = 0; i < 10; i++) add_hit(24'(i * 256), 24'(i * i * 64), i == 9);
      drain();

      // hold the sender until the block has gone idle
      hold_sender = 1'b1;
      repeat (3) add_random_track();
      repeat (40) @(posedge clock);
      hold_sender = 1'b0;
      drain();

      while (hits_sent + pending_hits.size() < 760) begin
         add_random_track();
         if (pending_hits.size() > 40)
            while (pending_hits.size() > 10) @(posedge clock);
      end
      drain();
      repeat (400) @(posedge clock);

      $display("%0d points sent, %0d fits checked (%0d degenerate, %0d with dropped points)",
               hits_sent, fits_seen, degen_seen, drop_seen);
      if (mismatches == 0 && expected_fits.size() == 0) begin
         $display("line_fit_with_chi_square verification clean");
      end else begin
         $display("%0d mismatches, %0d fits missing", mismatches, expected_fits.size());
         $display("line_fit_with_chi_square verification failed");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
design/lfc_pkg.sv
design/lfc_if.sv
design/lfc_datapath.sv
design/lfc_ctrl.sv
design/line_fit_with_chi_square.sv
tb/lfc_tb_pkg.sv
tb/tb_top.sv
